FILE: rtl/core/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared types and constants for the LRU key cache: command codes, field
// widths, control struct for the cell row and the sequencer states.
// ----------------------------------------------------------------------------
package lkc_pkg;

    // default sizes, used as the defaults of the top level parameters
    localparam int CAPACITY_DEF   = 512;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths of the stream beats
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int TDATA_W = 104;

    // cells per first-level group of the match reduction tree
    localparam int GROUP_SIZE = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_REDUCE,
        ST_MERGE,
        ST_UPDATE
    } state_t;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic compare;    // register key match
        logic shift_hit;  // shift cells at or above the hit position
        logic shift_all;  // shift the whole row, new entry at the head
        logic clear;      // invalidate every entry
    } lkc_ctrl_t;

endpackage

FILE: rtl/core/lru_key_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_cache_top
// Fully associative key cache with least recently used replacement, built as
// a row of entry cells kept in recency order, slot 0 the most recent.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command beat (lookup, insert or clear) with key and
//   handle; m_* returns exactly one result beat per command.
//   After the command beat is taken, the key is compared in every cell, the
//   match passes the registered levels of the match tree, and then the row
//   shifts and the result register loads. s_tready is high only while idle,
//   so a new command is taken only once the last one has left its final step.
//   A lookup hit and an insert of a new key shift the cell row by one place;
//   an insert into a full row drops the last cell and reports its key.
//   Reset clears every valid bit at once, so the cache is empty and ready
//   in the first cycle after reset; no clearing pass runs.
//   If the receiver stalls, the result waits in the output register and the
//   next command is still accepted; that command then holds in its final
//   step until the waiting result beat is taken.
// ----------------------------------------------------------------------------
module lru_key_cache_top
    import lkc_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // cmd[1:0], key[65:2], value[97:66], zero pad
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // hit[0], found_value[32:1], evicted[33],
                                          // evicted_key[97:34], zero pad
);

    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int STORE_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [STORE_BITS-1:0] value_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg, out_hit_next;
    logic [VALUE_W-1:0]    out_found_reg, out_found_next;
    logic                  out_evicted_reg, out_evicted_next;
    logic [KEY_W-1:0]      out_evk_reg, out_evk_next;
    logic                  out_load;

    lkc_ctrl_t             ctrl;
    logic [STORE_BITS-1:0] head_value;

    logic [KEY_W-1:0]      cell_key   [CAPACITY];
    logic [STORE_BITS-1:0] cell_value [CAPACITY];
    logic                  cell_valid [CAPACITY];
    logic                  cell_match [CAPACITY];

    logic                  found_hit;
    logic [IDX_W-1:0]      found_pos;
    logic [STORE_BITS-1:0] found_value;

    logic                  accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // command beat capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tdata[CMD_W-1:0];
            key_reg   <= s_tdata[CMD_W +: KEY_W];
            value_reg <= s_tdata[CMD_W + KEY_W +: STORE_BITS];
        end
    end

    // row of entry cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0]      prev_key;
        logic [STORE_BITS-1:0] prev_value;
        logic                  prev_valid;

        if (i == 0)
        begin : g_head
            assign prev_key   = key_reg;
            assign prev_value = head_value;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_key   = cell_key[i-1];
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
        end

        lkc_cell #(
            .IDX_W      (IDX_W),
            .STORE_BITS (STORE_BITS),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .hit_pos    (found_pos),
            .cmp_key    (key_reg),
            .prev_key   (prev_key),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .match      (cell_match[i])
        );
    end

    // match reduction tree
    lkc_reduce #(
        .CAPACITY    (CAPACITY),
        .IDX_W       (IDX_W),
        .STORE_BITS  (STORE_BITS)
    ) u_reduce (
        .clk         (clk),
        .cell_match  (cell_match),
        .cell_value  (cell_value),
        .found_hit   (found_hit),
        .found_pos   (found_pos),
        .found_value (found_value)
    );

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg     <= out_hit_next;
            out_found_reg   <= out_found_next;
            out_evicted_reg <= out_evicted_next;
            out_evk_reg     <= out_evk_next;
        end
    end

    // next state, cell control and result
    always_comb
    begin
        state_next       = state_reg;
        ctrl             = '0;
        head_value       = value_reg;
        out_load         = 1'b0;
        out_hit_next     = 1'b0;
        out_found_next   = '0;
        out_evicted_next = 1'b0;
        out_evk_next     = '0;
        out_valid_next   = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                ctrl.compare = 1'b1;
                state_next   = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    unique case (cmd_reg)
                        CMD_LOOKUP:
                        begin
                            if (found_hit)
                            begin
                                ctrl.shift_hit = 1'b1;
                                head_value     = found_value;
                                out_hit_next   = 1'b1;
                                out_found_next = VALUE_W'(found_value);
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (found_hit)
                            begin
                                out_hit_next   = 1'b1;
                                out_found_next = VALUE_W'(found_value);
                            end
                            else
                            begin
                                ctrl.shift_all   = 1'b1;
                                out_evicted_next = cell_valid[CAPACITY-1];
                                out_evk_next     = cell_valid[CAPACITY-1] ?
                                                   cell_key[CAPACITY-1] : '0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctrl.clear = 1'b1;
                        end
                        default:
                        begin
                            ctrl = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_evk_reg, out_evicted_reg, out_found_reg, out_hit_reg};

endmodule

FILE: rtl/core/lkc_cell.sv
// ----------------------------------------------------------------------------
// lkc_cell
// One slot of the recency row: holds a key, a handle and a valid bit,
// compares its key against the broadcast key and takes its neighbour's
// entry when the row shifts.
// ----------------------------------------------------------------------------
module lkc_cell
    import lkc_pkg::*;
#(
    parameter int IDX_W      = 9,
    parameter int STORE_BITS = 32,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkc_ctrl_t             ctrl,
    input  logic [IDX_W-1:0]      hit_pos,
    input  logic [KEY_W-1:0]      cmp_key,
    input  logic [KEY_W-1:0]      prev_key,
    input  logic [STORE_BITS-1:0] prev_value,
    input  logic                  prev_valid,
    output logic [KEY_W-1:0]      key,
    output logic [STORE_BITS-1:0] value,
    output logic                  valid,
    output logic                  match
);

    logic [KEY_W-1:0]      key_reg;
    logic [STORE_BITS-1:0] value_reg;
    logic                  valid_reg;
    logic                  match_reg;
    logic                  shift;

    // this slot moves down when the whole row shifts or lies at or above the hit
    assign shift = ctrl.shift_all || (ctrl.shift_hit && (IDX_W'(INDEX) <= hit_pos));

    // control state: valid and match flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                valid_reg <= 1'b0;
            end
            else if (shift)
            begin
                valid_reg <= prev_valid;
            end
            if (ctrl.compare)
            begin
                match_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

FILE: rtl/core/lkc_reduce.sv
// ----------------------------------------------------------------------------
// lkc_reduce
// Two-level registered OR tree over the cell match flags. At most one cell
// matches, so OR-ing masked positions and handles yields the hit entry.
// ----------------------------------------------------------------------------
module lkc_reduce
    import lkc_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int IDX_W      = 9,
    parameter int STORE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  cell_match [CAPACITY],
    input  logic [STORE_BITS-1:0] cell_value [CAPACITY],
    output logic                  found_hit,
    output logic [IDX_W-1:0]      found_pos,
    output logic [STORE_BITS-1:0] found_value
);

    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_N      = NUM_GROUPS * GROUP_SIZE;

    logic                  pad_match [PAD_N];
    logic [IDX_W-1:0]      pad_pos   [PAD_N];
    logic [STORE_BITS-1:0] pad_value [PAD_N];

    logic                  grp_hit_reg   [NUM_GROUPS];
    logic [IDX_W-1:0]      grp_pos_reg   [NUM_GROUPS];
    logic [STORE_BITS-1:0] grp_value_reg [NUM_GROUPS];

    logic                  hit_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [STORE_BITS-1:0] value_reg;

    // masked leaves, padded up to whole groups
    for (genvar p = 0; p < PAD_N; p++)
    begin : g_leaf
        if (p < CAPACITY)
        begin : g_real
            assign pad_match[p] = cell_match[p];
            assign pad_pos[p]   = cell_match[p] ? IDX_W'(p) : '0;
            assign pad_value[p] = cell_match[p] ? cell_value[p] : '0;
        end
        else
        begin : g_pad
            assign pad_match[p] = 1'b0;
            assign pad_pos[p]   = '0;
            assign pad_value[p] = '0;
        end
    end

    // first level: one register set per group
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        logic                  hit_next;
        logic [IDX_W-1:0]      pos_next;
        logic [STORE_BITS-1:0] value_next;

        always_comb
        begin
            hit_next   = 1'b0;
            pos_next   = '0;
            value_next = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                hit_next   = hit_next   | pad_match[g*GROUP_SIZE + j];
                pos_next   = pos_next   | pad_pos[g*GROUP_SIZE + j];
                value_next = value_next | pad_value[g*GROUP_SIZE + j];
            end
        end

        always_ff @(posedge clk)
        begin
            grp_hit_reg[g]   <= hit_next;
            grp_pos_reg[g]   <= pos_next;
            grp_value_reg[g] <= value_next;
        end
    end

    // second level: merge the groups
    logic                  hit_next;
    logic [IDX_W-1:0]      pos_next;
    logic [STORE_BITS-1:0] value_next;

    always_comb
    begin
        hit_next   = 1'b0;
        pos_next   = '0;
        value_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            hit_next   = hit_next   | grp_hit_reg[g];
            pos_next   = pos_next   | grp_pos_reg[g];
            value_next = value_next | grp_value_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        pos_reg   <= pos_next;
        value_reg <= value_next;
    end

    assign found_hit   = hit_reg;
    assign found_pos   = pos_reg;
    assign found_value = value_reg;

endmodule
